// ===== rtl/core/bqd_pkg.sv =====
// Shared types, constants and codes for the biquad filter block.
package bqd_pkg;

   // Default values of the top-level parameters.
   localparam int DEF_CHANNELS       = 8;
   localparam int DEF_SAMPLE_BITS    = 24;
   localparam int DEF_COEF_FRAC_BITS = 28;

   // Fixed field and register widths.
   localparam int COEF_BITS      = 32;
   localparam int NUM_COEFS      = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CHAN_BITS      = 3;
   localparam int DELAY_BITS     = 48;
   localparam int ALIGN_SHIFT    = 8;

   // Coefficient identifiers: register index on the CSR port and operand
   // select for the shared multiplier.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_id_type;

   // Controller states, one per step of the per-sample sequence.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_B0,
      ST_MUL_B1,
      ST_MUL_B2,
      ST_MUL_A1,
      ST_MUL_A2,
      ST_FOLD,
      ST_COMMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      coef_id_type mul_sel;
      logic        ld_delay;
      logic        ld_acc;
      logic        ld_y;
      logic        n1_init;
      logic        n2_init;
      logic        n1_sub;
      logic        n2_sub;
      logic        commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/biquad_tdf2_filter.sv =====
// Top level of the multichannel transposed direct form II biquad filter.
//
//   Channel  Direction  Handshake                Payload
//   req_     in         req_tvalid / req_tready  tdata: sample_in, tuser: chan_in
//   rsp_     out        rsp_tvalid / rsp_tready  tdata: sample_out, tuser: chan_out
//   csr_     in         csr_valid / csr_ready    csr_index, csr_data (coefficients)
//
// The block takes one sample at a time and accepts the next one only when the
// current sequence is done: one shared 32-bit multiplier forms the five
// coefficient products in turn, and a final step writes the channel's delay
// words back to the delay RAM and loads the output register.
// Reset is synchronous and active high. It clears all delay state (through
// per-channel valid bits, so there is no clearing pass) and restores the
// coefficients to a pass-through filter (b0 = 1.0, all others zero).
// The output register lets a finished result wait while the next input
// transaction is accepted; the sequence only stalls at writeback while the
// previous result has not been taken. The CSR port never stalls.
module biquad_tdf2_filter #(
   parameter int CHANNELS       = bqd_pkg::DEF_CHANNELS,
   parameter int SAMPLE_BITS    = bqd_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = bqd_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Input sample stream.
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]   req_tdata,  // sample_in
   input  logic [bqd_pkg::CHAN_BITS-1:0]              req_tuser,  // chan_in
   // Filtered sample stream.
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]   rsp_tdata,  // sample_out
   output logic [bqd_pkg::CHAN_BITS-1:0]              rsp_tuser,  // chan_out
   // Coefficient write port.
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [bqd_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [bqd_pkg::COEF_BITS-1:0]              csr_data
);
   import bqd_pkg::*;

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   dp_cmd_type             cmd;
   dp_status_type          status;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   // Coefficient writes are always taken; the write lands in the coefficient register.
   assign csr_ready = 1'b1;

   bqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bqd_datapath #(
      .CHANNELS       (CHANNELS),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .req_chan   (req_tuser),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_sample (rsp_sample),
      .rsp_chan   (rsp_tuser)
   );

   // Padding bits above the sample are zero.
   assign rsp_tdata = TDATA_W'(rsp_sample);

endmodule

// ===== rtl/core/bqd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bqd_ctrl.sv =====
// Sequencing state machine for the biquad filter: one sample at a time.
module bqd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bqd_pkg::dp_status_type status,
   output bqd_pkg::dp_cmd_type    cmd
);
   import bqd_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = COEF_B0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_MUL_B0;
            end
         end
         ST_MUL_B0: begin
            cmd.mul_sel  = COEF_B0;
            cmd.ld_delay = 1'b1;
            state_in     = ST_MUL_B1;
         end
         ST_MUL_B1: begin
            cmd.mul_sel = COEF_B1;
            cmd.ld_acc  = 1'b1;
            state_in    = ST_MUL_B2;
         end
         ST_MUL_B2: begin
            cmd.mul_sel = COEF_B2;
            cmd.ld_y    = 1'b1;
            cmd.n1_init = 1'b1;
            state_in    = ST_MUL_A1;
         end
         ST_MUL_A1: begin
            cmd.mul_sel = COEF_A1;
            cmd.n2_init = 1'b1;
            state_in    = ST_MUL_A2;
         end
         ST_MUL_A2: begin
            cmd.mul_sel = COEF_A2;
            cmd.n1_sub  = 1'b1;
            state_in    = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.n2_sub = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Hold here until the output register can take the result.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/bqd_datapath.sv =====
// Biquad datapath: coefficients, delay RAM, shared multiplier, accumulators, output register.
module bqd_datapath #(
   parameter int CHANNELS       = bqd_pkg::DEF_CHANNELS,
   parameter int SAMPLE_BITS    = bqd_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = bqd_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bqd_pkg::dp_cmd_type                 cmd,
   output bqd_pkg::dp_status_type              status,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   input  logic [bqd_pkg::CHAN_BITS-1:0]       req_chan,
   input  logic                                csr_valid,
   input  logic [bqd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bqd_pkg::COEF_BITS-1:0]       csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_BITS-1:0]              rsp_sample,
   output logic [bqd_pkg::CHAN_BITS-1:0]       rsp_chan
);
   import bqd_pkg::*;

   localparam int CIDX_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PROD_W          = COEF_BITS + SAMPLE_BITS;
   localparam int TERM_W          = PROD_W - ALIGN_SHIFT;
   localparam int ACC_W           = ((TERM_W > DELAY_BITS) ? TERM_W : DELAY_BITS) + 2;
   localparam int DELAY_FRAC_BITS = COEF_FRAC_BITS - ALIGN_SHIFT;
   localparam int QUO_W           = ACC_W - DELAY_FRAC_BITS;
   localparam int RAM_W           = 2 * DELAY_BITS;

   localparam logic [COEF_BITS-1:0]   COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);
   localparam logic [ACC_W-1:0]       ROUND_HALF = ACC_W'(64'd1 << (DELAY_FRAC_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = SAMPLE_BITS'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = ~SAMPLE_MIN;
   localparam logic [DELAY_BITS-1:0]  DELAY_MIN  = DELAY_BITS'(64'd1 << (DELAY_BITS - 1));
   localparam logic [DELAY_BITS-1:0]  DELAY_MAX  = ~DELAY_MIN;

   // Coefficient registers.
   logic [COEF_BITS-1:0] coef_ff [NUM_COEFS];
   logic [COEF_BITS-1:0] coef_in [NUM_COEFS];

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2: begin
               coef_in[csr_index] = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[COEF_B0] <= COEF_ONE;
         coef_ff[COEF_B1] <= '0;
         coef_ff[COEF_B2] <= '0;
         coef_ff[COEF_A1] <= '0;
         coef_ff[COEF_A2] <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Channel number folded into the delay store range.
   logic [CHAN_BITS-1:0] chan_wrap;

   always_comb begin
      chan_wrap = req_chan;
      for (int k = 0; k < (1 << CHAN_BITS); k++) begin
         if (int'(chan_wrap) >= CHANNELS) begin
            chan_wrap = chan_wrap - CHAN_BITS'(CHANNELS);
         end
      end
   end

   // Captured sample and channel.
   logic [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [CHAN_BITS-1:0]   chan_ff, chan_in;
   logic [CIDX_W-1:0]      idx_ff, idx_in;

   always_comb begin
      x_in    = x_ff;
      chan_in = chan_ff;
      idx_in  = idx_ff;
      if (cmd.capture) begin
         x_in    = req_sample;
         chan_in = req_chan;
         idx_in  = CIDX_W'(chan_wrap);
      end
   end

   // Delay store: both delay words of a channel in one RAM row, valid bits
   // in flops so that a never-written row reads as zero.
   logic [RAM_W-1:0]    ram_rd;
   logic [RAM_W-1:0]    ram_wr;
   logic [CHANNELS-1:0] valid_ff, valid_in;

   bqd_ram #(
      .WIDTH (RAM_W),
      .DEPTH (CHANNELS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (idx_ff),
      .wr_data (ram_wr),
      .rd_en   (cmd.capture),
      .rd_addr (CIDX_W'(chan_wrap)),
      .rd_data (ram_rd)
   );

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         valid_in[idx_ff] = 1'b1;
      end
   end

   logic [DELAY_BITS-1:0] r1_ff, r1_in;
   logic [DELAY_BITS-1:0] r2_ff, r2_in;

   always_comb begin
      r1_in = r1_ff;
      r2_in = r2_ff;
      if (cmd.ld_delay) begin
         r1_in = valid_ff[idx_ff] ? ram_rd[DELAY_BITS-1:0] : '0;
         r2_in = valid_ff[idx_ff] ? ram_rd[RAM_W-1:DELAY_BITS] : '0;
      end
   end

   // Shared multiplier with its product register.
   logic signed [COEF_BITS-1:0]   mul_a;
   logic signed [SAMPLE_BITS-1:0] mul_b;
   logic signed [PROD_W-1:0]      mul_p;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0]        y_ff, y_in;

   assign mul_a   = coef_ff[cmd.mul_sel];
   assign mul_b   = (cmd.mul_sel == COEF_A1 || cmd.mul_sel == COEF_A2) ? y_ff : x_ff;
   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p;

   // Product aligned to delay format (arithmetic shift right, floor) and
   // extended to accumulator width.
   logic [TERM_W-1:0] term;
   logic [ACC_W-1:0]  term_ext;
   logic [ACC_W-1:0]  r1_ext;
   logic [ACC_W-1:0]  r2_ext;

   assign term     = prod_ff[PROD_W-1:ALIGN_SHIFT];
   assign term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
   assign r1_ext   = {{(ACC_W-DELAY_BITS){r1_ff[DELAY_BITS-1]}}, r1_ff};
   assign r2_ext   = {{(ACC_W-DELAY_BITS){r2_ff[DELAY_BITS-1]}}, r2_ff};

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] n1_ff, n1_in;
   logic [ACC_W-1:0] n2_ff, n2_in;

   assign acc_in = cmd.ld_acc ? (term_ext + r1_ext) : acc_ff;

   always_comb begin
      n1_in = n1_ff;
      n2_in = n2_ff;
      if (cmd.n1_init) begin
         n1_in = term_ext + r2_ext;
      end else if (cmd.n1_sub) begin
         n1_in = n1_ff - term_ext;
      end
      if (cmd.n2_init) begin
         n2_in = term_ext;
      end else if (cmd.n2_sub) begin
         n2_in = n2_ff - term_ext;
      end
   end

   // Output sample: round half up to integer, then saturate.
   logic [ACC_W-1:0]           acc_rnd;
   logic [QUO_W-1:0]           quo;
   logic [QUO_W-SAMPLE_BITS:0] quo_hi;
   logic [SAMPLE_BITS-1:0]     y_sat;

   assign acc_rnd = acc_ff + ROUND_HALF;
   assign quo     = acc_rnd[ACC_W-1:DELAY_FRAC_BITS];
   assign quo_hi  = quo[QUO_W-1:SAMPLE_BITS-1];

   always_comb begin
      if ((&quo_hi) || !(|quo_hi)) begin
         y_sat = quo[SAMPLE_BITS-1:0];
      end else if (quo[QUO_W-1]) begin
         y_sat = SAMPLE_MIN;
      end else begin
         y_sat = SAMPLE_MAX;
      end
   end

   assign y_in = cmd.ld_y ? y_sat : y_ff;

   // New delay words saturated to the delay width.
   logic [ACC_W-DELAY_BITS:0] n1_hi;
   logic [ACC_W-DELAY_BITS:0] n2_hi;
   logic [DELAY_BITS-1:0]     n1_sat;
   logic [DELAY_BITS-1:0]     n2_sat;

   assign n1_hi = n1_ff[ACC_W-1:DELAY_BITS-1];
   assign n2_hi = n2_ff[ACC_W-1:DELAY_BITS-1];

   always_comb begin
      if ((&n1_hi) || !(|n1_hi)) begin
         n1_sat = n1_ff[DELAY_BITS-1:0];
      end else if (n1_ff[ACC_W-1]) begin
         n1_sat = DELAY_MIN;
      end else begin
         n1_sat = DELAY_MAX;
      end
      if ((&n2_hi) || !(|n2_hi)) begin
         n2_sat = n2_ff[DELAY_BITS-1:0];
      end else if (n2_ff[ACC_W-1]) begin
         n2_sat = DELAY_MIN;
      end else begin
         n2_sat = DELAY_MAX;
      end
   end

   assign ram_wr = {n2_sat, n1_sat};

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CHAN_BITS-1:0]   rsp_chan_ff, rsp_chan_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = y_ff;
         rsp_chan_in   = chan_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_chan        = rsp_chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      chan_ff       <= chan_in;
      idx_ff        <= idx_in;
      r1_ff         <= r1_in;
      r2_ff         <= r2_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      y_ff          <= y_in;
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
   end

endmodule
